### design/nkc_pkg.sv
// ----------------------------------------------------------------------------
// nkc_pkg
// Shared constants and types for the next k-combination stepper: parameter
// defaults, port field widths, configuration register indexes and reset values, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package nkc_pkg;

    // Parameter defaults
    localparam int MAX_POSITIONS_DEF = 16;
    localparam int ELEMENT_BITS_DEF  = 8;

    // Fixed field widths of the ports
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int SET_SIZE_W  = 8;
    localparam int COUNT_W     = 5;
    localparam int POSITION_W  = 4;
    localparam int VALUE_W     = 8;
    localparam int SLOT_W      = 4;
    localparam int ELEMENT_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_SIZE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHOOSE_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIXED_PREFIX = 2'd2;

    // Configuration reset values
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST     = 8'd8;
    localparam logic [COUNT_W-1:0]    CHOOSE_COUNT_RST = 5'd3;
    localparam logic [COUNT_W-1:0]    FIXED_PREFIX_RST = 5'd0;

    // Input opcodes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_FILL = 5'b00100,
        S_EMIT = 5'b01000,
        S_EXH  = 5'b10000
    } t_state;

endpackage

### design/nkc_ram.sv
// ----------------------------------------------------------------------------
// nkc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds until the next read.
// ----------------------------------------------------------------------------
module nkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/next_k_combination.sv
// ----------------------------------------------------------------------------
// next_k_combination
// Lexicographic next k-combination stepper over a position memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   opcode 0 writes i_value into position i_position, opcode 1 advances the
//   combination to its lexicographic successor. Output channel (o_out_valid /
//   i_out_stall) returns one transaction per position of the new combination
//   (slot, element, has_next = 1, last on position k-1), or a single
//   transaction with has_next = 0 and last = 1 when the combination is
//   exhausted. Writes return nothing.
//   An advance walks backward from position k-1, incrementing each position
//   until one stays below its ceiling, then refills the positions after it
//   in consecutive order and reads out and emits the k results; when the
//   walk reaches the fixed prefix without a hit, exhaustion is reported
//   instead. The position memory has one read and one write port, so the
//   walk, refill and read-out each step through one position at a time.
//   The input is stalled while an advance is in progress; a new item is taken
//   while the final result still waits in the output register.
//   A stall on the output holds the current result and pauses the read-out.
//   Reset restores set_size 8, choose_count 3, fixed_prefix 0 and idles the
//   sequencer; position memory contents are undefined until written.
// ----------------------------------------------------------------------------
module next_k_combination
    import nkc_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
    parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [POSITION_W-1:0] i_position,
    input  logic [VALUE_W-1:0]    i_value,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [ELEMENT_W-1:0]  o_element,
    output logic                  o_has_next,
    output logic                  o_last
);

    localparam int POS_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
    localparam int CMP_W = ELEMENT_BITS + 8;

    // Configuration registers
    logic [SET_SIZE_W-1:0] r_set_size;
    logic [COUNT_W-1:0]    r_choose_count;
    logic [COUNT_W-1:0]    r_fixed_prefix;

    // Sequencer state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_p, n_p;
    logic [SET_SIZE_W-1:0] r_n, n_n;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [ELEMENT_BITS-1:0] r_prev, n_prev;
    logic                r_pend, n_pend;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ELEMENT_W-1:0] r_element, n_element;
    logic                r_has_next, n_has_next;
    logic                r_last, n_last;

    // Memory port
    logic                    ram_we;
    logic [POS_W-1:0]        ram_waddr;
    logic [ELEMENT_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [POS_W-1:0]        ram_raddr;
    logic [ELEMENT_BITS-1:0] ram_rdata;

    // Derived values
    logic [CNT_W-1:0]        w_k_sat, w_p_sat, w_k_m1;
    logic [CNT_W-1:0]        w_i_m1, w_i_p1, w_j_p1, w_gap;
    logic [ELEMENT_BITS-1:0] w_inc, w_prev_inc;
    logic                    w_hit;
    logic                    w_out_free;

    nkc_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (MAX_POSITIONS),
        .AW    (POS_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Saturate k and the fixed prefix
    always_comb begin
        if (32'(r_choose_count) > MAX_POSITIONS) begin
            w_k_sat = CNT_W'(MAX_POSITIONS);
        end else begin
            w_k_sat = CNT_W'(r_choose_count);
        end
        if (32'(r_fixed_prefix) > 32'(w_k_sat)) begin
            w_p_sat = w_k_sat;
        end else begin
            w_p_sat = CNT_W'(r_fixed_prefix);
        end
    end

    assign w_k_m1     = w_k_sat - 1'b1;
    assign w_i_m1     = r_i - 1'b1;
    assign w_i_p1     = r_i + 1'b1;
    assign w_j_p1     = r_j + 1'b1;
    assign w_gap      = r_k - w_i_p1;
    assign w_inc      = ram_rdata + 1'b1;
    assign w_prev_inc = r_prev + 1'b1;
    // Position has not reached its ceiling: (v+1) + (k-1-i) != n
    assign w_hit      = (CMP_W'(w_inc) + CMP_W'(w_gap)) != CMP_W'(r_n);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_p         = r_p;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_prev      = r_prev;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_slot      = r_slot;
        n_element   = r_element;
        n_has_next  = r_has_next;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_waddr   = r_i[POS_W-1:0];
        ram_wdata   = w_inc;
        ram_re      = 1'b0;
        ram_raddr   = r_j[POS_W-1:0];

        // Drop a delivered result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_WRITE) begin
                        if (32'(i_position) < MAX_POSITIONS) begin
                            ram_we    = 1'b1;
                            ram_waddr = POS_W'(i_position);
                            ram_wdata = ELEMENT_BITS'(i_value);
                        end
                    end else begin
                        n_k = w_k_sat;
                        n_p = w_p_sat;
                        n_n = r_set_size;
                        if (w_p_sat == w_k_sat) begin
                            n_state = S_EXH;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = w_k_m1[POS_W-1:0];
                            n_i       = w_k_m1;
                            n_state   = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                // Increment position i and test its ceiling
                ram_we    = 1'b1;
                ram_waddr = r_i[POS_W-1:0];
                ram_wdata = w_inc;
                if (w_hit) begin
                    n_prev = w_inc;
                    if (w_i_p1 < r_k) begin
                        n_j     = w_i_p1;
                        n_state = S_FILL;
                    end else begin
                        n_j     = '0;
                        n_pend  = 1'b0;
                        n_state = S_EMIT;
                    end
                end else if (r_i == r_p) begin
                    n_state = S_EXH;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = w_i_m1[POS_W-1:0];
                    n_i       = w_i_m1;
                end
            end
            S_FILL: begin
                // Refill trailing positions consecutively
                ram_we    = 1'b1;
                ram_waddr = r_j[POS_W-1:0];
                ram_wdata = w_prev_inc;
                n_prev    = w_prev_inc;
                if (w_j_p1 == r_k) begin
                    n_j     = '0;
                    n_pend  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_j = w_j_p1;
                end
            end
            S_EMIT: begin
                // Read out positions, one transaction each
                if (!r_pend) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_j[POS_W-1:0];
                    n_pend    = 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_slot      = SLOT_W'(r_j);
                    n_element   = ELEMENT_W'(ram_rdata);
                    n_has_next  = 1'b1;
                    n_last      = (w_j_p1 == r_k);
                    if (w_j_p1 == r_k) begin
                        n_pend  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = w_j_p1[POS_W-1:0];
                        n_j       = w_j_p1;
                    end
                end
            end
            S_EXH: begin
                // Report exhaustion
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_slot      = '0;
                    n_element   = '0;
                    n_has_next  = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_set_size     <= SET_SIZE_RST;
            r_choose_count <= CHOOSE_COUNT_RST;
            r_fixed_prefix <= FIXED_PREFIX_RST;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SET_SIZE:     r_set_size     <= i_cfg_wdata;
                    CFG_CHOOSE_COUNT: r_choose_count <= COUNT_W'(i_cfg_wdata);
                    CFG_FIXED_PREFIX: r_fixed_prefix <= COUNT_W'(i_cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_p        <= n_p;
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_prev     <= n_prev;
        r_slot     <= n_slot;
        r_element  <= n_element;
        r_has_next <= n_has_next;
        r_last     <= n_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_element   = r_element;
    assign o_has_next  = r_has_next;
    assign o_last      = r_last;

endmodule
